// File: design/obk_pkg.sv
// Shared types, codes and sizes of the price-sorted order book.
package obk_pkg;

  localparam int SIDE_DEPTH = 32;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FILL   = 2'd2;
  localparam logic [1:0] KIND_NOFILL = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [63:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    logic [15:0] sym;
    logic        live;
  } entry_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        desc;
    logic        by_id;
    logic        tick;
    logic [31:0] market;
    entry_t      fresh;
  } ctl_t;

  typedef struct packed {
    logic ranks;
    logic gone;
    logic seen;
    logic found;
  } link_t;

endpackage

// File: design/obk_cell.sv
// One book entry cell that shifts toward either neighbor on insert or removal.
module obk_cell (
  input  logic           clk,
  input  logic           rst,
  input  obk_pkg::ctl_t  ctl,
  input  obk_pkg::entry_t left,
  input  obk_pkg::entry_t right,
  input  obk_pkg::link_t link_in,
  output obk_pkg::link_t link_out,
  output obk_pkg::entry_t ent,
  output logic           drop,
  output logic           match,
  output logic           kill,
  output logic           topsel
);
  logic ranks;
  obk_pkg::entry_t ent_next;

  always_comb begin
    ranks = ent.valid && (ctl.desc ? (ent.price >= ctl.fresh.price)
                                   : (ent.price <= ctl.fresh.price));
    drop  = ctl.tick && ent.valid && ent.live &&
            (ctl.desc ? (ent.price >= ctl.market) : (ent.price <= ctl.market));
    match = ent.valid && (ent.id == ctl.fresh.id);
    kill  = ctl.by_id ? match : (drop && !link_in.seen);
    topsel = ent.valid && !drop && !link_in.found;
    link_out.ranks = ranks;
    link_out.gone  = link_in.gone | kill;
    link_out.seen  = link_in.seen | drop;
    link_out.found = link_in.found | topsel;
    ent_next = ent;
    case (ctl.cmd)
      obk_pkg::CMD_INSERT: begin
        if (!ranks) begin
          ent_next = link_in.ranks ? ctl.fresh : left;
        end
      end
      obk_pkg::CMD_REMOVE: begin
        if (link_in.gone || kill) begin
          ent_next = right;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent.id    <= ent_next.id;
    ent.price <= ent_next.price;
    ent.qty   <= ent_next.qty;
    ent.sym   <= ent_next.sym;
    ent.live  <= ent_next.live;
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
  end
endmodule

// File: design/obk_side.sv
// One side of the book as a chain of entry cells with its summary logic.
module obk_side (
  input  logic            clk,
  input  logic            rst,
  input  obk_pkg::ctl_t   ctl,
  output logic            any_match,
  output logic            any_drop,
  output logic            one_drop,
  output logic            full,
  output logic [31:0]     top,
  output obk_pkg::entry_t pick
);
  localparam int N = obk_pkg::SIDE_DEPTH;

  obk_pkg::entry_t ents [N];
  obk_pkg::link_t  links [N+1];
  logic [N-1:0] drop_v, match_v, kill_v, top_v;

  assign links[0] = '{ranks: 1'b1, gone: 1'b0, seen: 1'b0, found: 1'b0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    obk_pkg::entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = ents[i-1];
    end
    if (i == N - 1) begin : g_end
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ents[i+1];
    end
    obk_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .left(left_e), .right(right_e),
      .link_in(links[i]), .link_out(links[i+1]), .ent(ents[i]),
      .drop(drop_v[i]), .match(match_v[i]), .kill(kill_v[i]), .topsel(top_v[i])
    );
  end

  always_comb begin
    top  = '0;
    pick = '0;
    for (int i = 0; i < N; i++) begin
      top  = top | (top_v[i] ? ents[i].price : 32'd0);
      pick = pick | (kill_v[i] ? ents[i] : obk_pkg::entry_t'('0));
    end
    any_match = |match_v;
    any_drop  = |drop_v;
    one_drop  = any_drop && ((drop_v & (drop_v - {{(N-1){1'b0}}, 1'b1})) == '0);
    full      = ents[N-1].valid;
  end
endmodule

// File: design/price_sorted_order_book.sv
// Top level of the price-sorted order book with its operation sequencer.
// Each transaction passes through capture, execute and best-price update before its first
// result. A tick then delivers one fill per cycle while the output is ready (or one no-fill
// result), bids in book order first, each fill pulled out of the cell chain by a single
// shift. The next transaction is accepted in the cycle after the last result is loaded;
// opcode 3 is taken with no result. Both sides hold SIDE_DEPTH entries; top_bid and
// top_ask always show the book after the whole operation.
module price_sorted_order_book (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] order_key,
  input  logic        side,
  input  logic [31:0] limit_price,
  input  logic [31:0] quantity,
  input  logic [15:0] instrument,
  input  logic        is_active,
  input  logic [31:0] tick_price,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic [63:0] fill_id,
  output logic [15:0] fill_instrument,
  output logic        fill_side,
  output logic [31:0] fill_price,
  output logic [31:0] fill_volume,
  output logic [31:0] top_bid,
  output logic [31:0] top_ask,
  output logic        last
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TOP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state, state_next;
  logic [1:0]  op;
  logic        sd;
  logic [1:0]  st, st_next;
  logic [31:0] market;
  logic [31:0] bid_hold, ask_hold;
  obk_pkg::entry_t fresh;
  obk_pkg::ctl_t bid_ctl, ask_ctl;
  logic bid_match, bid_drop, bid_one, bid_full;
  logic ask_match, ask_drop, ask_one, ask_full;
  logic [31:0] bid_top, ask_top;
  obk_pkg::entry_t bid_pick, ask_pick;
  logic out_free, load;
  logic [1:0] kind_next;
  logic fside_next, last_next;
  obk_pkg::entry_t fill_next;

  obk_side u_bid (
    .clk(clk), .rst(rst), .ctl(bid_ctl), .any_match(bid_match), .any_drop(bid_drop),
    .one_drop(bid_one), .full(bid_full), .top(bid_top), .pick(bid_pick)
  );
  obk_side u_ask (
    .clk(clk), .rst(rst), .ctl(ask_ctl), .any_match(ask_match), .any_drop(ask_drop),
    .one_drop(ask_one), .full(ask_full), .top(ask_top), .pick(ask_pick)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    bid_ctl = '{cmd: obk_pkg::CMD_HOLD, desc: 1'b1, by_id: 1'b0,
                tick: (op == obk_pkg::OP_TICK) && (state == S_TOP || state == S_EMIT),
                market: market, fresh: fresh};
    ask_ctl = bid_ctl;
    ask_ctl.desc = 1'b0;
    state_next = state;
    st_next = st;
    load = 1'b0;
    kind_next = obk_pkg::KIND_ADD;
    fside_next = 1'b0;
    last_next = 1'b1;
    fill_next = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (opcode == obk_pkg::OP_NONE) ? S_IDLE : S_EXEC;
        end
      end
      S_EXEC: begin
        if (op == obk_pkg::OP_ADD) begin
          if (bid_match || ask_match) begin
            st_next = obk_pkg::ST_DUP;
          end else if (sd ? ask_full : bid_full) begin
            st_next = obk_pkg::ST_FULL;
          end else begin
            st_next = obk_pkg::ST_OK;
            if (sd) begin
              ask_ctl.cmd = obk_pkg::CMD_INSERT;
            end else begin
              bid_ctl.cmd = obk_pkg::CMD_INSERT;
            end
          end
        end else if (op == obk_pkg::OP_CANCEL) begin
          st_next = (bid_match || ask_match) ? obk_pkg::ST_OK : obk_pkg::ST_UNKNOWN;
          bid_ctl.cmd = obk_pkg::CMD_REMOVE;
          bid_ctl.by_id = 1'b1;
          ask_ctl.cmd = obk_pkg::CMD_REMOVE;
          ask_ctl.by_id = 1'b1;
        end else begin
          st_next = obk_pkg::ST_OK;
        end
        state_next = S_TOP;
      end
      S_TOP: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (op != obk_pkg::OP_TICK) begin
            kind_next = (op == obk_pkg::OP_CANCEL) ? obk_pkg::KIND_CANCEL
                                                   : obk_pkg::KIND_ADD;
            state_next = S_IDLE;
          end else if (bid_drop) begin
            kind_next = obk_pkg::KIND_FILL;
            fill_next = bid_pick;
            bid_ctl.cmd = obk_pkg::CMD_REMOVE;
            last_next = bid_one && !ask_drop;
          end else if (ask_drop) begin
            kind_next = obk_pkg::KIND_FILL;
            fill_next = ask_pick;
            fside_next = 1'b1;
            ask_ctl.cmd = obk_pkg::CMD_REMOVE;
            last_next = ask_one;
          end else begin
            kind_next = obk_pkg::KIND_NOFILL;
          end
          if (last_next) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op <= opcode;
      sd <= side;
      market <= tick_price;
      fresh <= '{valid: 1'b1, id: order_key, price: limit_price, qty: quantity,
                 sym: instrument, live: is_active};
    end
    st <= st_next;
    if (state == S_TOP) begin
      bid_hold <= bid_top;
      ask_hold <= ask_top;
    end
    if (load) begin
      kind <= kind_next;
      status <= (kind_next == obk_pkg::KIND_FILL || kind_next == obk_pkg::KIND_NOFILL)
                ? obk_pkg::ST_OK : st;
      fill_id <= fill_next.id;
      fill_instrument <= fill_next.sym;
      fill_side <= fside_next;
      fill_price <= fill_next.price;
      fill_volume <= fill_next.qty;
      top_bid <= bid_hold;
      top_ask <= ask_hold;
      last <= last_next;
    end
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
